// File: hw/rtl/pdc_pkg.sv
// Shared widths, register indices and reset values for the PID duty controller.
package pdc_pkg;

  localparam int unsigned LevelW  = 12;
  localparam int unsigned DutyW   = 13;
  localparam int unsigned GainW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FracW   = 24;

  localparam logic [DutyW-1:0] FullScale = 13'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETPOINT  = 3'd0,
    CFG_FF_CENTER = 3'd1,
    CFG_FF_GAIN   = 3'd2,
    CFG_GAIN_P    = 3'd3,
    CFG_GAIN_I    = 3'd4,
    CFG_GAIN_D    = 3'd5
  } cfg_reg_e;

  localparam logic [LevelW-1:0]       SetpointRst = 12'd2662;
  localparam logic [LevelW-1:0]       FfCenterRst = 12'd2458;
  localparam logic signed [GainW-1:0] FfGainRst   = 32'sd83886080;
  localparam logic signed [GainW-1:0] GainPRst    = -32'sd167772160;
  localparam logic signed [GainW-1:0] GainIRst    = -32'sd1678;
  localparam logic signed [GainW-1:0] GainDRst    = -32'sd167772;

endpackage

// File: hw/rtl/pdc_if.sv
// Valid/ready channel interfaces for sensor samples and duty results.
interface pdc_sample_if;
  logic                         valid;
  logic                         ready;
  logic [pdc_pkg::LevelW-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pdc_result_if;
  logic                            valid;
  logic                            ready;
  logic [pdc_pkg::DutyW-1:0]       duty;
  logic signed [pdc_pkg::GainW-1:0] raw_duty;
  logic                            clamped_low;
  logic                            clamped_high;

  modport source (output valid, output duty, output raw_duty, output clamped_low,
                  output clamped_high, input ready);
  modport sink   (input valid, input duty, input raw_duty, input clamped_low,
                  input clamped_high, output ready);
endinterface

// File: hw/rtl/pid_duty_controller.sv
// PID duty controller: feedforward plus P, I and D terms, clamped to full scale.
// Path: an accepted sample waits in the input register, and its result in the result register.
// Throughput: one sample per cycle while results are taken; the input register feeds
// the result register through one pass of four parallel multipliers and a 64-bit adder.
// Reset: gains and levels return to their defaults, integral and previous error
// clear to zero, and both pipeline registers are emptied.
module pid_duty_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pdc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pdc_pkg::GainW-1:0]   cfg_wdata_i,
  pdc_sample_if.sink                  sample_if,
  pdc_result_if.source                result_if
);
  import pdc_pkg::*;

  // Configuration registers
  logic [LevelW-1:0]       setpoint_q, ff_center_q;
  logic signed [GainW-1:0] ff_gain_q, gain_p_q, gain_i_q, gain_d_q;

  // Controller state
  logic signed [LevelW:0]  prev_error_q;
  logic signed [GainW-1:0] integral_q, integral_d;

  // Input stage
  logic              in_valid_q;
  logic [LevelW-1:0] sample_q;

  // Result stage
  logic                    out_valid_q;
  logic [DutyW-1:0]        duty_q, duty_d;
  logic signed [GainW-1:0] raw_q, raw_d;
  logic                    low_q, low_d, high_q, high_d;

  logic advance;

  assign advance         = in_valid_q && (!out_valid_q || result_if.ready);
  assign sample_if.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= SetpointRst;
      ff_center_q <= FfCenterRst;
      ff_gain_q   <= FfGainRst;
      gain_p_q    <= GainPRst;
      gain_i_q    <= GainIRst;
      gain_d_q    <= GainDRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SETPOINT:  setpoint_q  <= cfg_wdata_i[LevelW-1:0];
        CFG_FF_CENTER: ff_center_q <= cfg_wdata_i[LevelW-1:0];
        CFG_FF_GAIN:   ff_gain_q   <= signed'(cfg_wdata_i);
        CFG_GAIN_P:    gain_p_q    <= signed'(cfg_wdata_i);
        CFG_GAIN_I:    gain_i_q    <= signed'(cfg_wdata_i);
        CFG_GAIN_D:    gain_d_q    <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic signed [LevelW:0]   error, ff_delta;
  logic signed [LevelW+1:0] diff;
  logic signed [GainW:0]    int_sum;
  logic signed [GainW-1:0]  int_sat;
  logic signed [44:0]       prod_ff, prod_p;
  logic signed [45:0]       prod_d;
  logic signed [63:0]       prod_i, acc;
  logic signed [63:0]       shifted;
  logic signed [39:0]       shifted_w;

  assign error    = signed'({1'b0, setpoint_q}) - signed'({1'b0, sample_q});
  assign ff_delta = signed'({1'b0, setpoint_q}) - signed'({1'b0, ff_center_q});
  assign diff     = 14'(error) - 14'(prev_error_q);

  // Integral accumulates with saturation at the 32-bit limits.
  assign int_sum = 33'(integral_q) + 33'(error);
  always_comb begin
    if (int_sum[GainW] != int_sum[GainW-1]) begin
      int_sat = int_sum[GainW] ? {1'b1, {(GainW-1){1'b0}}} : {1'b0, {(GainW-1){1'b1}}};
    end else begin
      int_sat = int_sum[GainW-1:0];
    end
  end

  assign prod_ff = 45'(ff_gain_q) * 45'(ff_delta);
  assign prod_p  = 45'(gain_p_q) * 45'(error);
  assign prod_i  = 64'(gain_i_q) * 64'(int_sat);
  assign prod_d  = 46'(gain_d_q) * 46'(diff);

  // The products fit 64 bits exactly; the arithmetic shift rounds towards minus infinity.
  assign acc       = 64'(prod_ff) + 64'(prod_p) + prod_i + 64'(prod_d);
  assign shifted   = acc >>> FracW;
  assign shifted_w = shifted[39:0];

  always_comb begin
    if (shifted_w[39:31] != {9{shifted_w[31]}}) begin
      raw_d = shifted_w[39] ? {1'b1, {(GainW-1){1'b0}}} : {1'b0, {(GainW-1){1'b1}}};
    end else begin
      raw_d = shifted_w[31:0];
    end
    low_d      = raw_d[GainW-1];
    high_d     = !low_d && (raw_d > 32'(FullScale));
    integral_d = low_d ? '0 : int_sat;
    if (low_d) begin
      duty_d = '0;
    end else if (high_d) begin
      duty_d = FullScale;
    end else begin
      duty_d = raw_d[DutyW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      prev_error_q <= '0;
      integral_q   <= '0;
    end else begin
      if (sample_if.ready) begin
        in_valid_q <= sample_if.valid;
      end
      if (advance) begin
        out_valid_q  <= 1'b1;
        prev_error_q <= error;
        integral_q   <= integral_d;
      end else if (result_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_if.valid && sample_if.ready) begin
      sample_q <= sample_if.sample;
    end
    if (advance) begin
      duty_q <= duty_d;
      raw_q  <= raw_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign result_if.valid        = out_valid_q;
  assign result_if.duty         = duty_q;
  assign result_if.raw_duty     = raw_q;
  assign result_if.clamped_low  = low_q;
  assign result_if.clamped_high = high_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_clamp_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(low_q && high_q))
    else $error("both clamp flags set on one result");

  a_low_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && low_q) |-> (duty_q == '0) && raw_q[GainW-1])
    else $error("low clamp without zero duty and negative raw sum");

  a_antiwindup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && low_d) |=> (integral_q == '0))
    else $error("integral not cleared after a negative raw sum");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(sample_q))
    else $error("pending sample lost or overwritten");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_if.ready) |=> out_valid_q && $stable(raw_q)
      && $stable(duty_q))
    else $error("stalled result changed");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PID duty controller, with its own model of the duty loop.
module tb_top;
  import pdc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam logic [GainW-1:0]   GainMax    = 32'h7FFF_FFFF;
  localparam logic [GainW-1:0]   GainMin    = 32'h8000_0000;
  localparam logic [LevelW-1:0]  LevelMax   = 12'd4095;
  localparam longint             RawMax     = 64'sd2147483647;
  localparam longint             RawMin     = -64'sd2147483648;
  // Samples at full error in a row, to let the integral build up in one direction.
  localparam int unsigned        RunItems   = 16;
  localparam int unsigned        HoldCycles = 200;
  localparam int unsigned        PhaseItems = 45;

  typedef struct packed {
    logic [DutyW-1:0]        duty;
    logic signed [GainW-1:0] raw_duty;
    logic                    clamped_low;
    logic                    clamped_high;
  } duty_res_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_idx;
  logic [GainW-1:0]     cfg_wdata;

  pdc_sample_if smp_ch ();
  pdc_result_if res_ch ();

  pid_duty_controller i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .sample_if  (smp_ch),
    .result_if  (res_ch)
  );

  // Register copies and loop state held by the checker.
  logic [LevelW-1:0]       reg_setpoint  = SetpointRst;
  logic [LevelW-1:0]       reg_ff_center = FfCenterRst;
  logic signed [GainW-1:0] reg_ff_gain   = FfGainRst;
  logic signed [GainW-1:0] reg_gain_p    = GainPRst;
  logic signed [GainW-1:0] reg_gain_i    = GainIRst;
  logic signed [GainW-1:0] reg_gain_d    = GainDRst;
  logic signed [DutyW-1:0] pid_prev_err  = '0;
  logic signed [GainW-1:0] pid_integ     = '0;

  logic [LevelW-1:0] pending_samples[$];
  duty_res_t         expected_duty[$];
  int unsigned       mismatch_count = 0;
  bit                sample_taken   = 1'b0;
  bit                idle_on        = 1'b1;
  bit                stall_req      = 1'b0;
  int unsigned       send_gap       = 0;
  int unsigned       ready_gap      = 0;
  int unsigned       hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(50_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic duty_res_t duty_predict(logic [LevelW-1:0] smp);
    longint    err;
    longint    dif;
    longint    acc;
    longint    raw;
    duty_res_t r;
    err = longint'(reg_setpoint) - longint'(smp);
    dif = err - longint'(pid_prev_err);
    acc = longint'(pid_integ) + err;
    if (acc > RawMax) acc = RawMax;
    else if (acc < RawMin) acc = RawMin;
    pid_integ = acc[GainW-1:0];
    // Every term is a signed integer times a Q8.24 gain; the whole sum fits in 64 bits before the shift.
    acc = longint'(reg_ff_gain) * (longint'(reg_setpoint) - longint'(reg_ff_center))
        + longint'(reg_gain_p) * err
        + longint'(reg_gain_i) * longint'(pid_integ)
        + longint'(reg_gain_d) * dif;
    raw = acc >>> FracW;
    if (raw > RawMax) raw = RawMax;
    else if (raw < RawMin) raw = RawMin;
    r.raw_duty     = raw[GainW-1:0];
    r.clamped_low  = 1'b0;
    r.clamped_high = 1'b0;
    if (raw < 0) begin
      r.duty        = '0;
      r.clamped_low = 1'b1;
      pid_integ     = '0;
    end else if (raw > longint'(FullScale)) begin
      r.duty         = FullScale;
      r.clamped_high = 1'b1;
    end else begin
      r.duty = raw[DutyW-1:0];
    end
    pid_prev_err = err[DutyW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [GainW-1:0] rand_gain(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return $urandom();
    if (pick == 1) return $urandom_range(1) ? GainMax : GainMin;
    if (pick == 2) return '0;
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic logic [LevelW-1:0] rand_sample();
    int unsigned pick;
    int          v;
    pick = $urandom_range(9);
    if (pick < 4) begin
      // Hover around the setpoint so the output lands between the clamps as well.
      v = int'(reg_setpoint) + int'($urandom_range(128)) - 64;
      if (v < 0) v = 0;
      if (v > int'(LevelMax)) v = int'(LevelMax);
      return v[LevelW-1:0];
    end
    if (pick < 8) return LevelW'($urandom_range(LevelMax));
    return $urandom_range(1) ? LevelMax : '0;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_SETPOINT:  reg_setpoint  = data[LevelW-1:0];
      CFG_FF_CENTER: reg_ff_center = data[LevelW-1:0];
      CFG_FF_GAIN:   reg_ff_gain   = data;
      CFG_GAIN_P:    reg_gain_p    = data;
      CFG_GAIN_I:    reg_gain_i    = data;
      CFG_GAIN_D:    reg_gain_d    = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued sample has gone in and every result has come back.
  task automatic settle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || smp_ch.valid || expected_duty.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin : sample_driver
    if (rst_n && (!smp_ch.valid || sample_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        smp_ch.valid  <= 1'b0;
        smp_ch.sample <= LevelW'($urandom_range(LevelMax));
      end else if (pending_samples.size() != 0) begin
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= pending_samples.pop_front();
        send_gap = idle_on ? idle_len() : 0;
      end else begin
        smp_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_ready_driver
    if (rst_n) begin
      if (stall_req) begin
        hold_left = HoldCycles;
        stall_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        ready_gap = idle_on ? idle_len() : 0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    duty_res_t want;
    sample_taken = rst_n && smp_ch.valid && smp_ch.ready;
    if (sample_taken) expected_duty.push_back(duty_predict(smp_ch.sample));
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_duty.size() == 0) begin
        report_mismatch($sformatf("result transaction with nothing expected: duty %0d raw %0d",
                                  res_ch.duty, res_ch.raw_duty));
      end else begin
        want = expected_duty.pop_front();
        if (res_ch.duty !== want.duty)
          report_mismatch($sformatf("duty: got %0d, expected %0d", res_ch.duty, want.duty));
        if (res_ch.raw_duty !== want.raw_duty)
          report_mismatch($sformatf("raw_duty: got %0d, expected %0d",
                                    res_ch.raw_duty, want.raw_duty));
        if (res_ch.clamped_low !== want.clamped_low)
          report_mismatch($sformatf("clamped_low: got %b, expected %b",
                                    res_ch.clamped_low, want.clamped_low));
        if (res_ch.clamped_high !== want.clamped_high)
          report_mismatch($sformatf("clamped_high: got %b, expected %b",
                                    res_ch.clamped_high, want.clamped_high));
      end
    end
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    smp_ch.valid  = 1'b0;
    smp_ch.sample = '0;
    res_ch.ready  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: both clamps and the span between them.
    pending_samples = '{12'd0, LevelMax, 12'd2662, 12'd2662, LevelMax, 12'd0, 12'd1, 12'd2048};
    settle();

    write_reg(CFG_SETPOINT, 32'd4095);
    write_reg(CFG_FF_CENTER, 32'd0);
    write_reg(CFG_FF_GAIN, GainMax);
    write_reg(CFG_GAIN_P, GainMin);
    write_reg(CFG_GAIN_I, GainMax);
    write_reg(CFG_GAIN_D, GainMin);
    pending_samples = '{12'd0, LevelMax, 12'd0};
    settle();

    write_reg(CFG_SETPOINT, 32'd0);
    write_reg(CFG_FF_CENTER, 32'd4095);
    write_reg(CFG_FF_GAIN, GainMin);
    write_reg(CFG_GAIN_P, GainMax);
    write_reg(CFG_GAIN_I, GainMin);
    write_reg(CFG_GAIN_D, GainMax);
    pending_samples = '{LevelMax, 12'd0, LevelMax};
    settle();

    // Only the low bits of a wide write land, and spare indices are ignored.
    write_reg(CFG_SETPOINT, 32'hFFFF_F9A6);
    write_reg(CFG_FF_CENTER, 32'hABCD_E123);
    write_reg(CfgSpareLo, $urandom());
    write_reg(CfgSpareHi, $urandom());
    write_reg(CFG_FF_GAIN, FfGainRst);
    write_reg(CFG_GAIN_P, GainPRst);
    write_reg(CFG_GAIN_I, GainIRst);
    write_reg(CFG_GAIN_D, GainDRst);
    pending_samples = '{12'd2470, 12'd0, LevelMax, 12'd1234};
    settle();

    // Integral growth upwards: a tiny positive integral gain keeps raw
    // non-negative, so nothing clears the integral on the way.
    idle_on = 1'b0;
    write_reg(CFG_SETPOINT, 32'd4095);
    write_reg(CFG_FF_CENTER, 32'd4095);
    write_reg(CFG_GAIN_P, 32'd0);
    write_reg(CFG_GAIN_D, 32'd0);
    write_reg(CFG_GAIN_I, 32'd1);
    for (int k = 0; k < RunItems; k++) pending_samples.push_back('0);
    settle();
    write_reg(CFG_GAIN_I, GainMax);
    pending_samples = '{12'd0, 12'd0};
    settle();
    write_reg(CFG_GAIN_I, GainMin);
    pending_samples = '{12'd0};
    settle();

    // Integral growth downwards, starting from the cleared integral.
    write_reg(CFG_SETPOINT, 32'd0);
    write_reg(CFG_FF_CENTER, 32'd0);
    write_reg(CFG_GAIN_I, 32'hFFFF_FFFF);
    for (int k = 0; k < RunItems; k++) pending_samples.push_back(LevelMax);
    settle();
    write_reg(CFG_GAIN_I, GainMin);
    pending_samples = '{LevelMax, LevelMax};
    settle();
    write_reg(CFG_GAIN_I, GainMax);
    pending_samples = '{LevelMax};
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      if ($urandom_range(2) != 0) write_reg(CFG_SETPOINT, $urandom());
      if ($urandom_range(2) != 0) write_reg(CFG_FF_CENTER, $urandom());
      if ($urandom_range(2) != 0) write_reg(CFG_FF_GAIN, rand_gain(1 << 25));
      if ($urandom_range(2) != 0) write_reg(CFG_GAIN_P, rand_gain(1 << 25));
      if ($urandom_range(2) != 0) write_reg(CFG_GAIN_I, rand_gain(1 << 16));
      if ($urandom_range(2) != 0) write_reg(CFG_GAIN_D, rand_gain(1 << 25));
      if ($urandom_range(5) == 0) write_reg(CfgSpareHi, $urandom());
      // One phase holds the result side off long enough to back the pipeline up.
      idle_on = !(ph == 3 || ph == 5);
      if (ph == 3) stall_req = 1'b1;
      for (int k = 0; k < PhaseItems; k++) pending_samples.push_back(rand_sample());
      settle();
    end

    if (expected_duty.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_duty.size()));
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_if.sv
hw/rtl/pid_duty_controller.sv
tb/tb_top.sv
